// ----- rtl/core/seo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_pkg
// Widths, shifts and shared types for the two-body outgoing energy pipeline.
// ----------------------------------------------------------------------------
package seo_pkg;

    // energy fixed point
    localparam int ENERGY_FRAC_BITS = 16;
    localparam int E_W              = 32;
    localparam int COS_W            = 16;
    localparam int RATIO_W          = 20;
    localparam int RATIO_FRAC       = 16;
    localparam int RATIO_ONE        = 1 << RATIO_FRAC;
    localparam int A_W              = RATIO_W + 1;
    localparam int D_W              = 2 * A_W;
    localparam int IN_DATA_W        = E_W + COS_W + E_W;
    localparam int USER_W           = 3;

    // sqrt(E) with E scaled to 32 fraction bits
    localparam int E_SHIFT    = 32 - ENERGY_FRAC_BITS;
    localparam int E64_W      = E_W + E_SHIFT;
    localparam int SQ1_STEPS  = (E64_W + 1) / 2;

    // T = r * |mu| * sqrt(E), 46 fraction bits
    localparam int RM_W       = RATIO_W + COS_W;
    localparam int T_W        = RM_W + SQ1_STEPS;
    localparam int TL_W       = T_W / 2;
    localparam int TH_W       = T_W - TL_W;
    localparam int T2_W       = 2 * T_W;

    // constant term products, aligned to 92 fraction bits
    localparam int DISC_ALIGN = 28;
    localparam int CP_W       = RATIO_W + E_W + 1;
    localparam int CPL_W      = CP_W / 2;
    localparam int CPH_W      = CP_W - CPL_W;
    localparam int CPA_W      = CP_W + A_W;
    localparam int CM_W       = E_W + A_W;
    localparam int TERM_SH    = E_SHIFT + DISC_ALIGN;
    localparam int CM_SH      = E_SHIFT + RATIO_FRAC + DISC_ALIGN;
    localparam int DISC_W     = ((T2_W > CM_W + CM_SH) ? T2_W : CM_W + CM_SH) + 1;

    // square root cell widths, sized for the discriminant root
    localparam int SQ2_STEPS  = (DISC_W + 1) / 2;
    localparam int RAD_W      = 2 * SQ2_STEPS;
    localparam int ROOT_W     = SQ2_STEPS;
    localparam int REM_W      = SQ2_STEPS + 2;

    // root numerators and their squares
    localparam int N_W        = ROOT_W + 1;
    localparam int NL_W       = N_W / 2;
    localparam int NH_W       = N_W - NL_W;
    localparam int NSQ_W      = 2 * N_W;
    localparam int N2_SH      = 60 - ENERGY_FRAC_BITS;
    localparam int N2_W       = NSQ_W - N2_SH;

    // quotient
    localparam int Q_W        = 32;
    localparam int DIV_STEPS  = Q_W;

    // restoring square root cell state
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_st_t;

    // restoring divider cell state
    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [Q_W-1:0] num;
        logic [Q_W-1:0] quo;
    } div_st_t;

    // input beat fields
    typedef struct packed {
        logic [E_W-1:0]   exc;
        logic [COS_W-1:0] cos;
        logic [E_W-1:0]   inc;
    } item_t;

    // sideband next to the discriminant root chain
    typedef struct packed {
        logic [T_W-1:0] t;
        logic           neg;
        logic           noroot;
    } root_side_t;

    // sideband next to the divider chains
    typedef struct packed {
        logic sat_p;
        logic sat_m;
        logic noroot;
    } div_side_t;

    // result beat fields
    typedef struct packed {
        logic           sat;
        logic           minus;
        logic           noroot;
        logic [Q_W-1:0] energy;
    } result_t;

endpackage

// ----- rtl/core/scatter_outgoing_energy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_outgoing_energy
// Outgoing energy of a two-body scatter: root of (1+r)q^2 + bq + c = 0,
// squared, through chains of square root and divider cells.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_       | in  | tdata: inc_energy[31:0], lab_cosine[47:32], excite_energy[79:48]
//  m_       | out | tdata: out_energy; tuser: no_real_root, minus_root_used, saturated
//  cfg_     | in  | data: mass_ratio (Q4.16)
//
// One beat per cycle while s_tready is high; a beat runs from acceptance to m_tvalid
// through the 24-cell sqrt(E) chain, the 61-cell discriminant root chain and the
// 32-cell divider chains, plus ten arithmetic stages and the output register.
// Reset empties the pipeline and sets mass_ratio to 1.0.
// The pipeline holds only when both the output register and the skid stage
// carry a beat; s_tready then drops.
// ----------------------------------------------------------------------------
module scatter_outgoing_energy import seo_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // inc_energy, lab_cosine, excite_energy
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [Q_W-1:0]       m_tdata,   // out_energy
    output logic [USER_W-1:0]    m_tuser,   // no_real_root, minus_root_used, saturated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RATIO_W-1:0]   cfg_data
);

    // configuration
    logic [RATIO_W-1:0] mass_ratio_reg;
    logic [A_W-1:0]     a_reg;
    logic [D_W-1:0]     d_reg;

    logic en;

    // sqrt(E) chain
    item_t           in_item;
    logic [E64_W-1:0] e64;
    logic [SQ1_STEPS:0] v1;
    sqrt_st_t        st1 [SQ1_STEPS+1];
    item_t           side1_reg [SQ1_STEPS];
    item_t           side1_end;
    logic [COS_W-1:0] mag;

    // arithmetic stages ahead of the discriminant root
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic                 neg_a_reg, neg_b_reg, neg_c_reg, neg_d_reg, neg_e_reg, neg_f_reg;
    logic [RM_W-1:0]      rm_a_reg;
    logic [SQ1_STEPS-1:0] se_a_reg;
    logic [CP_W-1:0]      cpn_a_reg;
    logic [CM_W-1:0]      cmn_a_reg, cmn_b_reg, cmn_c_reg, cmn_d_reg;
    logic [T_W-1:0]       t_b_reg, t_c_reg, t_d_reg, t_e_reg, t_f_reg;
    logic [CPL_W+A_W-1:0] cpal_b_reg;
    logic [CPH_W+A_W-1:0] cpah_b_reg;
    logic [CPA_W-1:0]     cpa_c_reg, cpa_d_reg;
    logic [2*TL_W-1:0]    tll_c_reg;
    logic [TL_W+TH_W-1:0] tlh_c_reg;
    logic [2*TH_W-1:0]    thh_c_reg;
    logic [T2_W-1:0]      t2_d_reg;
    logic [DISC_W-1:0]    lhs_e_reg, termp_e_reg, disc_f_reg;
    logic [DISC_W:0]      disc_sub;
    logic                 noroot_f_reg;

    // discriminant root chain
    logic [SQ2_STEPS:0] v2;
    sqrt_st_t           st2 [SQ2_STEPS+1];
    root_side_t         side2_reg [SQ2_STEPS];
    root_side_t         side2_end;

    // numerators, squares and divider setup
    logic [N_W-1:0]     s_x, t_x, n_sum, n_dif;
    logic               vg_reg, vh_reg, vi_reg, vj_reg;
    logic               noroot_g_reg, noroot_h_reg, noroot_i_reg, noroot_j_reg;
    logic [N_W-1:0]     n_g_reg [2];
    logic [2*NL_W-1:0]  nll_h_reg [2];
    logic [NL_W+NH_W-1:0] nlh_h_reg [2];
    logic [2*NH_W-1:0]  nhh_h_reg [2];
    logic [NSQ_W-1:0]   nsq [2];
    logic [N2_W-1:0]    n2_i_reg [2];
    logic               sat_j_reg [2];
    div_st_t            dinit_j_reg [2];

    // divider chains, plus root first
    logic [DIV_STEPS:0] vdv [2];
    div_st_t            dst [2][DIV_STEPS+1];
    div_side_t          side3_reg [DIV_STEPS];
    div_side_t          side3_end;

    // result and output buffering
    result_t res;
    logic    res_valid;
    logic    m_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    // configuration register and derived 1+r and (1+r)^2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_ratio_reg <= RATIO_W'(RATIO_ONE);
        end else if (cfg_valid) begin
            mass_ratio_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= A_W'(mass_ratio_reg) + A_W'(RATIO_ONE);
        d_reg <= D_W'(a_reg) * D_W'(a_reg);
    end

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_tready  = en;

    // input beat into the sqrt(E) chain
    always_comb begin
        in_item.inc   = s_tdata[E_W-1:0];
        in_item.cos   = s_tdata[E_W+COS_W-1:E_W];
        in_item.exc   = s_tdata[IN_DATA_W-1:E_W+COS_W];
        e64           = E64_W'(in_item.inc) << E_SHIFT;
    end

    assign st1[0].rad  = RAD_W'(e64) << (RAD_W - 2 * SQ1_STEPS);
    assign st1[0].rem  = '0;
    assign st1[0].root = '0;
    assign v1[0]       = s_tvalid;

    for (genvar i = 0; i < SQ1_STEPS; i++) begin : g_sq1
        seo_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v1[i]),
            .in_st     (st1[i]),
            .out_valid (v1[i+1]),
            .out_st    (st1[i+1])
        );
    end

    // sideband shift line beside the sqrt(E) chain
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg[0] <= in_item;
            for (int i = 1; i < SQ1_STEPS; i++) begin
                side1_reg[i] <= side1_reg[i-1];
            end
        end
    end

    assign side1_end = side1_reg[SQ1_STEPS-1];
    assign mag = side1_end.cos[COS_W-1] ? (~side1_end.cos + COS_W'(1)) : side1_end.cos;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
        end else if (en) begin
            va_reg <= v1[SQ1_STEPS];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= v2[SQ2_STEPS];
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
        end
    end

    assign disc_sub = {1'b0, lhs_e_reg} - {1'b0, termp_e_reg};

    // products and quarter discriminant
    always_ff @(posedge aclk) begin
        if (en) begin
            // r*|mu|, r*E + Ex, E*(1+r)
            neg_a_reg <= side1_end.cos[COS_W-1];
            rm_a_reg  <= RM_W'(mass_ratio_reg) * RM_W'(mag);
            se_a_reg  <= st1[SQ1_STEPS].root[SQ1_STEPS-1:0];
            cpn_a_reg <= CP_W'(mass_ratio_reg) * CP_W'(side1_end.inc)
                         + (CP_W'(side1_end.exc) << RATIO_FRAC);
            cmn_a_reg <= CM_W'(side1_end.inc) * CM_W'(a_reg);
            // T and the halves of the constant term times (1+r)
            neg_b_reg  <= neg_a_reg;
            t_b_reg    <= T_W'(rm_a_reg) * T_W'(se_a_reg);
            cpal_b_reg <= (CPL_W+A_W)'(cpn_a_reg[CPL_W-1:0]) * (CPL_W+A_W)'(a_reg);
            cpah_b_reg <= (CPH_W+A_W)'(cpn_a_reg[CP_W-1:CPL_W]) * (CPH_W+A_W)'(a_reg);
            cmn_b_reg  <= cmn_a_reg;
            // partial products of T^2, constant term times (1+r)
            neg_c_reg <= neg_b_reg;
            t_c_reg   <= t_b_reg;
            tll_c_reg <= (2*TL_W)'(t_b_reg[TL_W-1:0]) * (2*TL_W)'(t_b_reg[TL_W-1:0]);
            tlh_c_reg <= (TL_W+TH_W)'(t_b_reg[TL_W-1:0])
                         * (TL_W+TH_W)'(t_b_reg[T_W-1:TL_W]);
            thh_c_reg <= (2*TH_W)'(t_b_reg[T_W-1:TL_W]) * (2*TH_W)'(t_b_reg[T_W-1:TL_W]);
            cpa_c_reg <= (CPA_W'(cpah_b_reg) << CPL_W) + CPA_W'(cpal_b_reg);
            cmn_c_reg <= cmn_b_reg;
            // T^2
            neg_d_reg <= neg_c_reg;
            t_d_reg   <= t_c_reg;
            t2_d_reg  <= (T2_W'(thh_c_reg) << (2 * TL_W))
                         + (T2_W'(tlh_c_reg) << (TL_W + 1)) + T2_W'(tll_c_reg);
            cpa_d_reg <= cpa_c_reg;
            cmn_d_reg <= cmn_c_reg;
            // both sides of the discriminant
            neg_e_reg   <= neg_d_reg;
            t_e_reg     <= t_d_reg;
            lhs_e_reg   <= DISC_W'(t2_d_reg) + (DISC_W'(cmn_d_reg) << CM_SH);
            termp_e_reg <= DISC_W'(cpa_d_reg) << TERM_SH;
            // difference, borrow means no real root
            neg_f_reg    <= neg_e_reg;
            t_f_reg      <= t_e_reg;
            disc_f_reg   <= disc_sub[DISC_W-1:0];
            noroot_f_reg <= disc_sub[DISC_W];
        end
    end

    // discriminant root chain
    assign st2[0].rad  = RAD_W'(disc_f_reg);
    assign st2[0].rem  = '0;
    assign st2[0].root = '0;
    assign v2[0]       = vf_reg;

    for (genvar i = 0; i < SQ2_STEPS; i++) begin : g_sq2
        seo_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v2[i]),
            .in_st     (st2[i]),
            .out_valid (v2[i+1]),
            .out_st    (st2[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg[0].t      <= t_f_reg;
            side2_reg[0].neg    <= neg_f_reg;
            side2_reg[0].noroot <= noroot_f_reg;
            for (int i = 1; i < SQ2_STEPS; i++) begin
                side2_reg[i] <= side2_reg[i-1];
            end
        end
    end

    assign side2_end = side2_reg[SQ2_STEPS-1];

    // numerators -T + S and -T - S as magnitudes
    always_comb begin
        s_x   = N_W'(st2[SQ2_STEPS].root);
        t_x   = N_W'(side2_end.t);
        n_sum = s_x + t_x;
        n_dif = (s_x >= t_x) ? (s_x - t_x) : (t_x - s_x);
    end

    for (genvar k = 0; k < 2; k++) begin : g_sq
        assign nsq[k] = (NSQ_W'(nhh_h_reg[k]) << (2 * NL_W))
                        + (NSQ_W'(nlh_h_reg[k]) << (NL_W + 1)) + NSQ_W'(nll_h_reg[k]);
    end

    // squares, scaling and divider setup
    always_ff @(posedge aclk) begin
        if (en) begin
            noroot_g_reg <= side2_end.noroot;
            n_g_reg[0]   <= side2_end.neg ? n_sum : n_dif;
            n_g_reg[1]   <= side2_end.neg ? n_dif : n_sum;
            noroot_h_reg <= noroot_g_reg;
            noroot_i_reg <= noroot_h_reg;
            noroot_j_reg <= noroot_i_reg;
            for (int k = 0; k < 2; k++) begin
                nll_h_reg[k] <= (2*NL_W)'(n_g_reg[k][NL_W-1:0])
                                * (2*NL_W)'(n_g_reg[k][NL_W-1:0]);
                nlh_h_reg[k] <= (NL_W+NH_W)'(n_g_reg[k][NL_W-1:0])
                                * (NL_W+NH_W)'(n_g_reg[k][N_W-1:NL_W]);
                nhh_h_reg[k] <= (2*NH_W)'(n_g_reg[k][N_W-1:NL_W])
                                * (2*NH_W)'(n_g_reg[k][N_W-1:NL_W]);
                n2_i_reg[k]  <= nsq[k][NSQ_W-1:N2_SH];
                sat_j_reg[k] <= (n2_i_reg[k][N2_W-1:Q_W] >= (N2_W-Q_W)'(d_reg));
                dinit_j_reg[k].rem <= n2_i_reg[k][Q_W+D_W-1:Q_W];
                dinit_j_reg[k].num <= n2_i_reg[k][Q_W-1:0];
                dinit_j_reg[k].quo <= '0;
            end
        end
    end

    // divider chains
    for (genvar k = 0; k < 2; k++) begin : g_div
        assign vdv[k][0] = vj_reg;
        assign dst[k][0] = dinit_j_reg[k];
        for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
            seo_div_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .divisor   (d_reg),
                .in_valid  (vdv[k][i]),
                .in_st     (dst[k][i]),
                .out_valid (vdv[k][i+1]),
                .out_st    (dst[k][i+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg[0].sat_p  <= sat_j_reg[0];
            side3_reg[0].sat_m  <= sat_j_reg[1];
            side3_reg[0].noroot <= noroot_j_reg;
            for (int i = 1; i < DIV_STEPS; i++) begin
                side3_reg[i] <= side3_reg[i-1];
            end
        end
    end

    assign side3_end = side3_reg[DIV_STEPS-1];

    // root selection; a saturated plus root counts as nonzero
    always_comb begin
        res_valid  = vdv[0][DIV_STEPS] & vdv[1][DIV_STEPS] & en;
        res.energy = '0;
        res.noroot = 1'b0;
        res.minus  = 1'b0;
        res.sat    = 1'b0;
        if (side3_end.noroot) begin
            res.noroot = 1'b1;
        end else if (side3_end.sat_p || (dst[0][DIV_STEPS].quo != '0)) begin
            res.energy = side3_end.sat_p ? {Q_W{1'b1}} : dst[0][DIV_STEPS].quo;
            res.sat    = side3_end.sat_p;
        end else begin
            res.energy = side3_end.sat_m ? {Q_W{1'b1}} : dst[1][DIV_STEPS].quo;
            res.minus  = 1'b1;
            res.sat    = side3_end.sat_m;
        end
    end

    // output register and skid stage, control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg    <= skid_valid_reg | res_valid;
            skid_valid_reg <= 1'b0;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid stage, data
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (!skid_valid_reg) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.energy;
    assign m_tuser  = {out_reg.sat, out_reg.minus, out_reg.noroot};

endmodule

// ----- rtl/core/seo_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_sqrt_cell
// One step of a restoring square root: brings in two radicand bits and
// decides one root bit, then registers the state for the next cell.
// ----------------------------------------------------------------------------
module seo_sqrt_cell import seo_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  sqrt_st_t in_st,
    output logic     out_valid,
    output sqrt_st_t out_st
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             ge;
    sqrt_st_t         st_next;
    sqrt_st_t         st_reg;
    logic             valid_reg;

    // trial subtract of (4*root + 1)
    always_comb begin
        rem_sh       = {in_st.rem[REM_W-3:0], in_st.rad[RAD_W-1 -: 2]};
        trial        = {in_st.root, 2'b01};
        ge           = (rem_sh >= trial);
        diff         = rem_sh - trial;
        st_next.rad  = in_st.rad << 2;
        st_next.rem  = ge ? diff : rem_sh;
        st_next.root = {in_st.root[ROOT_W-2:0], ge};
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

// ----- rtl/core/seo_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_div_cell
// One step of a restoring divider: shifts in one numerator bit and
// decides one quotient bit against the shared divisor.
// ----------------------------------------------------------------------------
module seo_div_cell import seo_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [D_W-1:0] divisor,
    input  logic           in_valid,
    input  div_st_t        in_st,
    output logic           out_valid,
    output div_st_t        out_st
);

    logic [D_W:0] rem_sh;
    logic [D_W:0] diff;
    logic         ge;
    div_st_t      st_next;
    div_st_t      st_reg;
    logic         valid_reg;

    // trial subtract of the divisor
    always_comb begin
        rem_sh      = {in_st.rem, in_st.num[Q_W-1]};
        ge          = (rem_sh >= {1'b0, divisor});
        diff        = rem_sh - {1'b0, divisor};
        st_next.rem = ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
        st_next.num = in_st.num << 1;
        st_next.quo = {in_st.quo[Q_W-2:0], ge};
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule
